@@ src/bgr_pkg.sv @@
// Package for the button gesture and repeat block: constants, register codes, shared types.
package bgr_pkg;

   localparam int TIME_WIDTH_DEF  = 32;
   localparam int NOW_WIDTH       = 32;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int DEBOUNCE_WIDTH  = 8;
   localparam int TIMING_WIDTH    = 16;
   localparam int TALLY_WIDTH     = 2;
   localparam int DELTA_WIDTH     = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DEBOUNCE_TIME   = 3'd0,
      REG_LONG_PRESS_TIME = 3'd1,
      REG_DOUBLE_WINDOW   = 3'd2,
      REG_ACCEL_TIME      = 3'd3,
      REG_FAST_INTERVAL   = 3'd4,
      REG_SLOW_INTERVAL   = 3'd5
   } reg_index_type;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET   = 8'd20;
   localparam logic [TIMING_WIDTH-1:0]   LONG_PRESS_RESET = 16'd800;
   localparam logic [TIMING_WIDTH-1:0]   DOUBLE_WIN_RESET = 16'd300;
   localparam logic [TIMING_WIDTH-1:0]   ACCEL_RESET      = 16'd1000;
   localparam logic [TIMING_WIDTH-1:0]   FAST_INT_RESET   = 16'd50;
   localparam logic [TIMING_WIDTH-1:0]   SLOW_INT_RESET   = 16'd250;

   localparam logic [TALLY_WIDTH-1:0] TALLY_ONE = 2'd1;
   localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = 2'd2;

   // Debounced view of one button for the current item.
   typedef struct packed {
      logic level;    // 1 = pressed, after this item's debounce
      logic press;    // press accepted on this item
      logic lift;     // release accepted on this item
   } deb_type;

   typedef struct packed {
      logic short_ev;
      logic long_ev;
      logic double_ev;
   } gest_type;

endpackage

@@ src/bgr_req_if.sv @@
// Poll item channel: timestamp and four active-low button pins.
interface bgr_req_if;
   logic                          valid;
   logic                          ready;
   logic [bgr_pkg::NOW_WIDTH-1:0] now_ms;
   logic                          menu_pin;
   logic                          set_pin;
   logic                          plus_pin;
   logic                          minus_pin;

   modport source (output valid, now_ms, menu_pin, set_pin, plus_pin, minus_pin,
                   input ready);
   modport sink   (input valid, now_ms, menu_pin, set_pin, plus_pin, minus_pin,
                   output ready);
endinterface

@@ src/bgr_rsp_if.sv @@
// Result item channel: gesture events and trim step.
interface bgr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   menu_short;
   logic                                   menu_long;
   logic                                   set_short;
   logic                                   set_long;
   logic                                   set_double;
   logic signed [bgr_pkg::DELTA_WIDTH-1:0] trim_delta;

   modport source (output valid, menu_short, menu_long, set_short, set_long, set_double,
                   trim_delta, input ready);
   modport sink   (input valid, menu_short, menu_long, set_short, set_long, set_double,
                   trim_delta, output ready);
endinterface

@@ src/bgr_debounce.sv @@
// Debouncer for one button: holds the stable level and time of last accepted change.
module bgr_debounce #(
   parameter int TIME_WIDTH = bgr_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic                                level,
   input  logic [TIME_WIDTH-1:0]               now,
   input  logic [bgr_pkg::DEBOUNCE_WIDTH-1:0]  debounce_time,
   output bgr_pkg::deb_type                    deb
);
   import bgr_pkg::*;

   logic                  stable_ff, stable_in;
   logic [TIME_WIDTH-1:0] change_ff, change_in;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  take;

   assign elapsed = now - change_ff;
   assign take    = (level != stable_ff) && (elapsed >= TIME_WIDTH'(debounce_time));

   always_comb begin
      stable_in = stable_ff;
      change_in = change_ff;
      if (fire && take) begin
         stable_in = level;
         change_in = now;
      end
   end

   assign deb.level = take ? level : stable_ff;
   assign deb.press = take && level;
   assign deb.lift  = take && !level;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         change_ff <= '0;
      end else begin
         stable_ff <= stable_in;
         change_ff <= change_in;
      end
   end
endmodule

@@ src/bgr_gesture.sv @@
// Click, long press and double click classifier for one button.
module bgr_gesture #(
   parameter int TIME_WIDTH = bgr_pkg::TIME_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  bgr_pkg::deb_type                  deb,
   input  logic [TIME_WIDTH-1:0]             now,
   input  logic [bgr_pkg::TIMING_WIDTH-1:0]  long_press_time,
   input  logic [bgr_pkg::TIMING_WIDTH-1:0]  double_window,
   output bgr_pkg::gest_type                 gest
);
   import bgr_pkg::*;

   logic [TIME_WIDTH-1:0]  press_ff, press_in;
   logic [TIME_WIDTH-1:0]  release_ff, release_in;
   logic [TALLY_WIDTH-1:0] tally_ff, tally_in;
   logic                   long_done_ff, long_done_in;

   logic [TIME_WIDTH-1:0]  held_for;
   logic [TIME_WIDTH-1:0]  idle_for;
   logic [TALLY_WIDTH-1:0] tally_mid;
   logic                   long_done_mid;
   logic                   long_hit;
   logic                   click_hit;

   // Times of a change on this item read as zero elapsed.
   assign held_for = deb.press ? '0 : (now - press_ff);
   assign idle_for = deb.lift  ? '0 : (now - release_ff);

   assign long_done_mid = deb.press ? 1'b0 : long_done_ff;
   assign tally_mid     = (deb.lift && !long_done_ff && (tally_ff < TALLY_MAX))
                          ? (tally_ff + TALLY_ONE) : tally_ff;

   assign long_hit  = deb.level && !long_done_mid &&
                      (held_for >= TIME_WIDTH'(long_press_time));
   assign click_hit = !deb.level && (tally_mid != '0) &&
                      (idle_for > TIME_WIDTH'(double_window));

   assign gest.long_ev   = long_hit;
   assign gest.short_ev  = click_hit && (tally_mid == TALLY_ONE);
   assign gest.double_ev = click_hit && (tally_mid != TALLY_ONE);

   always_comb begin
      press_in     = press_ff;
      release_in   = release_ff;
      tally_in     = tally_ff;
      long_done_in = long_done_ff;
      if (fire) begin
         if (deb.press) press_in = now;
         if (deb.lift) release_in = now;
         long_done_in = long_done_mid || long_hit;
         tally_in     = (long_hit || click_hit) ? '0 : tally_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff     <= '0;
         release_ff   <= '0;
         tally_ff     <= '0;
         long_done_ff <= 1'b0;
      end else begin
         press_ff     <= press_in;
         release_ff   <= release_in;
         tally_ff     <= tally_in;
         long_done_ff <= long_done_in;
      end
   end
endmodule

@@ src/bgr_trim.sv @@
// Trim button auto-repeat: step on press, then slow then fast repeat while held.
module bgr_trim #(
   parameter int TIME_WIDTH = bgr_pkg::TIME_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  bgr_pkg::deb_type                  deb,
   input  logic [TIME_WIDTH-1:0]             now,
   input  logic [bgr_pkg::TIMING_WIDTH-1:0]  accel_time,
   input  logic [bgr_pkg::TIMING_WIDTH-1:0]  fast_interval,
   input  logic [bgr_pkg::TIMING_WIDTH-1:0]  slow_interval,
   output logic                              step
);
   import bgr_pkg::*;

   logic                  held_ff, held_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic [TIME_WIDTH-1:0] last_ff, last_in;
   logic [TIME_WIDTH-1:0] since_start;
   logic [TIME_WIDTH-1:0] since_last;
   logic [TIMING_WIDTH-1:0] interval;
   logic                  due;

   assign since_start = now - start_ff;
   assign since_last  = now - last_ff;
   assign interval    = (since_start > TIME_WIDTH'(accel_time)) ? fast_interval : slow_interval;
   assign due         = since_last >= TIME_WIDTH'(interval);

   always_comb begin
      held_in  = held_ff;
      start_in = start_ff;
      last_in  = last_ff;
      step     = 1'b0;
      if (deb.level && !held_ff) begin
         held_in  = 1'b1;
         start_in = now;
         last_in  = now;
         step     = 1'b1;
      end else if (!deb.level && held_ff) begin
         held_in = 1'b0;
      end else if (held_ff && due) begin
         last_in = now;
         step    = 1'b1;
      end
      if (!fire) begin
         held_in  = held_ff;
         start_in = start_ff;
         last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         start_ff <= '0;
         last_ff  <= '0;
      end else begin
         held_ff  <= held_in;
         start_ff <= start_in;
         last_ff  <= last_in;
      end
   end
endmodule

@@ src/button_gesture_and_repeat.sv @@
// Top level: poll register, debouncers, gesture and trim logic, result register, CSRs.
// Path: a poll item accepted passes through the poll reg, then the result reg.
// Throughput: one poll item per cycle while the result channel is not stalled; each
//   item updates the button state in the cycle it moves from the poll register into the result register.
// Reset: synchronous, active high; clears both valid flags and all button state,
//   and loads the registers with their default times.
module button_gesture_and_repeat #(
   parameter int TIME_WIDTH = bgr_pkg::TIME_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bgr_req_if.sink                              req_chan,
   bgr_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [bgr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bgr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import bgr_pkg::*;

   // Configuration registers
   logic [DEBOUNCE_WIDTH-1:0] debounce_ff;
   logic [TIMING_WIDTH-1:0]   long_press_ff;
   logic [TIMING_WIDTH-1:0]   double_win_ff;
   logic [TIMING_WIDTH-1:0]   accel_ff;
   logic [TIMING_WIDTH-1:0]   fast_int_ff;
   logic [TIMING_WIDTH-1:0]   slow_int_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         double_win_ff <= DOUBLE_WIN_RESET;
         accel_ff      <= ACCEL_RESET;
         fast_int_ff   <= FAST_INT_RESET;
         slow_int_ff   <= SLOW_INT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEBOUNCE_TIME:   debounce_ff   <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            REG_LONG_PRESS_TIME: long_press_ff <= csr_wdata;
            REG_DOUBLE_WINDOW:   double_win_ff <= csr_wdata;
            REG_ACCEL_TIME:      accel_ff      <= csr_wdata;
            REG_FAST_INTERVAL:   fast_int_ff   <= csr_wdata;
            REG_SLOW_INTERVAL:   slow_int_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake: the poll register moves on whenever the result register is
   // empty or being drained; a stalled result holds the poll register, and
   // a full poll register that cannot move on holds off the next item.
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic fire;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // Poll register: pressed levels are stored active high.
   logic [NOW_WIDTH-1:0] now_ff;
   logic [3:0]           level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         now_ff   <= req_chan.now_ms;
         level_ff <= {!req_chan.minus_pin, !req_chan.plus_pin,
                      !req_chan.set_pin, !req_chan.menu_pin};
      end
   end

   // Time base trimmed or extended to the internal width; all time
   // differences wrap at that width.
   logic [TIME_WIDTH-1:0] now;
   assign now = TIME_WIDTH'(now_ff);

   // Debounce all four buttons: menu, set, plus, minus.
   deb_type deb [4];

   for (genvar b = 0; b < 4; b++) begin : g_deb
      bgr_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb (
         .clock         (clock),
         .reset         (reset),
         .fire          (fire),
         .level         (level_ff[b]),
         .now           (now),
         .debounce_time (debounce_ff),
         .deb           (deb[b])
      );
   end

   // Gestures on menu and set. A menu double click clears its tally but
   // is not reported.
   gest_type menu_gest, set_gest;

   bgr_gesture #(.TIME_WIDTH(TIME_WIDTH)) u_menu_gest (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .deb             (deb[0]),
      .now             (now),
      .long_press_time (long_press_ff),
      .double_window   (double_win_ff),
      .gest            (menu_gest)
   );

   bgr_gesture #(.TIME_WIDTH(TIME_WIDTH)) u_set_gest (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .deb             (deb[1]),
      .now             (now),
      .long_press_time (long_press_ff),
      .double_window   (double_win_ff),
      .gest            (set_gest)
   );

   // Trim auto-repeat on plus and minus.
   logic plus_step, minus_step;

   bgr_trim #(.TIME_WIDTH(TIME_WIDTH)) u_plus_trim (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .deb           (deb[2]),
      .now           (now),
      .accel_time    (accel_ff),
      .fast_interval (fast_int_ff),
      .slow_interval (slow_int_ff),
      .step          (plus_step)
   );

   bgr_trim #(.TIME_WIDTH(TIME_WIDTH)) u_minus_trim (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .deb           (deb[3]),
      .now           (now),
      .accel_time    (accel_ff),
      .fast_interval (fast_int_ff),
      .slow_interval (slow_int_ff),
      .step          (minus_step)
   );

   // plus minus minus: 01, 11 or 00
   logic signed [DELTA_WIDTH-1:0] delta;
   assign delta = $signed({1'b0, plus_step}) - $signed({1'b0, minus_step});

   // Result register
   logic                          menu_short_ff, menu_long_ff;
   logic                          set_short_ff, set_long_ff, set_double_ff;
   logic signed [DELTA_WIDTH-1:0] trim_delta_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         menu_short_ff <= menu_gest.short_ev;
         menu_long_ff  <= menu_gest.long_ev;
         set_short_ff  <= set_gest.short_ev;
         set_long_ff   <= set_gest.long_ev;
         set_double_ff <= set_gest.double_ev;
         trim_delta_ff <= delta;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.menu_short = menu_short_ff;
   assign rsp_chan.menu_long  = menu_long_ff;
   assign rsp_chan.set_short  = set_short_ff;
   assign rsp_chan.set_long   = set_long_ff;
   assign rsp_chan.set_double = set_double_ff;
   assign rsp_chan.trim_delta = trim_delta_ff;

endmodule
